/* rtl/sc3_pkg.sv */
// sc3_pkg: shared types and constants for the 3x3 sharpen / edge filter
// used by sc3_conv_core and sharpen_edge_conv3x3_top; no dependencies
package sc3_pkg;

    // kernel codes
    localparam logic [1:0] KERN_CROSS_LAP = 2'd0;
    localparam logic [1:0] KERN_BOX_LAP   = 2'd1;
    localparam logic [1:0] KERN_SOBEL_H   = 2'd2;
    localparam logic [1:0] KERN_SOBEL_V   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_KERNEL_SELECT = 2'd0;
    localparam logic [1:0] REG_CENTER_BOOST  = 2'd1;
    localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd2;
    localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd3;

    localparam int PIX_W   = 8;
    localparam int CFG_W   = 13;
    localparam int WIDTH_W = 11;
    localparam int HEIGHT_W = 13;
    localparam int MIN_DIM = 3;

    // weighted sum range: about -2040 .. 67065
    localparam int SUM_W = 20;
    localparam int PIX_MAX = 255;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic signed [SUM_W-1:0] sum_t;

    // filter setup seen by the core
    typedef struct packed {
        logic [1:0] kernel_select;
        pix_t       center_boost;
    } sc3_filt_cfg_t;

    // per-beat tags carried alongside the pixel
    typedef struct packed {
        logic produce;
        logic row_end;
        logic frame_end;
    } sc3_tag_t;

    function automatic sum_t px_ext(input pix_t x);
        px_ext = $signed({{(SUM_W-PIX_W){1'b0}}, x});
    endfunction

endpackage

/* rtl/sc3_ram.sv */
// sc3_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module sc3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/sc3_conv_core.sv */
// sc3_conv_core: 3x3 window register and kernel arithmetic with clamp
// depends on sc3_pkg
module sc3_conv_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  shift_en,
    input  sc3_pkg::pix_t         up_pix,
    input  sc3_pkg::pix_t         mid_pix,
    input  sc3_pkg::pix_t         new_pix,
    input  sc3_pkg::sc3_filt_cfg_t filt_cfg,
    output sc3_pkg::pix_t         result
);
    import sc3_pkg::*;

    pix_t win_reg  [3][3];
    pix_t win_next [3][3];
    sum_t t00, t01, t02, t10, t11, t12, t20, t21, t22;
    sum_t boost_term;
    sum_t acc;
    logic [2*PIX_W-1:0] boost_prod;

    // window as it looks after this beat shifts in
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_next[r][0] = win_reg[r][1];
            win_next[r][1] = win_reg[r][2];
        end
        win_next[0][2] = up_pix;
        win_next[1][2] = mid_pix;
        win_next[2][2] = new_pix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
        end
        else if (shift_en)
        begin
            win_reg <= win_next;
        end
    end

    assign t00 = px_ext(win_next[0][0]);
    assign t01 = px_ext(win_next[0][1]);
    assign t02 = px_ext(win_next[0][2]);
    assign t10 = px_ext(win_next[1][0]);
    assign t11 = px_ext(win_next[1][1]);
    assign t12 = px_ext(win_next[1][2]);
    assign t20 = px_ext(win_next[2][0]);
    assign t21 = px_ext(win_next[2][1]);
    assign t22 = px_ext(win_next[2][2]);

    assign boost_prod = filt_cfg.center_boost * win_next[1][1];
    assign boost_term = $signed({{(SUM_W-2*PIX_W){1'b0}}, boost_prod});

    always_comb
    begin
        case (filt_cfg.kernel_select)
            KERN_CROSS_LAP:
            begin
                acc = (t11 <<< 2) - t01 - t10 - t12 - t21 + boost_term;
            end
            KERN_BOX_LAP:
            begin
                acc = (t11 <<< 3) - t00 - t01 - t02 - t10 - t12 - t20 - t21 - t22
                      + boost_term;
            end
            KERN_SOBEL_H:
            begin
                acc = t02 - t00 + ((t12 - t10) <<< 1) + t22 - t20;
            end
            KERN_SOBEL_V:
            begin
                acc = t20 - t00 + ((t21 - t01) <<< 1) + t22 - t02;
            end
            default:
            begin
                acc = '0;
            end
        endcase
    end

    // clamp to 0..255
    always_comb
    begin
        if (acc < 0)
        begin
            result = '0;
        end
        else if (acc > sum_t'(PIX_MAX))
        begin
            result = pix_t'(PIX_MAX);
        end
        else
        begin
            result = acc[PIX_W-1:0];
        end
    end

endmodule

/* rtl/sharpen_edge_conv3x3_top.sv */
// sharpen_edge_conv3x3_top: streaming 3x3 Laplacian / Sobel filter with line buffers
// depends on sc3_pkg, sc3_ram, sc3_conv_core

// Takes one 8-bit grey pixel per beat in raster order and returns one filtered
// pixel for every interior position, so a W x H frame yields (W-2) x (H-2) results,
// with row_end on the last result of each output row and frame_end on the last of
// the frame. Throughput is one pixel per clock: a pixel is accepted in every cycle
// that the output side does not stall, and its result passes from acceptance
// through stage 1, which registers the line-buffer read, then through the kernel
// arithmetic into the output register. The two line buffers are MAX_LINE-deep RAMs
// read once and written once per beat; their contents are undefined after reset and
// need no clearing pass, since every entry is written on the first line before it
// is read for a result. Configuration (kernel_select, center_boost, image_width,
// image_height) is written through the cfg port, which is always ready; change it
// only between frames while the block is idle. Width and height are saturated to
// 3..MAX_LINE and 3..MAX_ROWS.
module sharpen_edge_conv3x3_top #(
    parameter int MAX_LINE = 1024,
    parameter int MAX_ROWS = 4096
) (
    input  logic                      clk,
    input  logic                      rst_n,

    // configuration write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [sc3_pkg::CFG_W-1:0] cfg_data,

    // pixel input channel
    input  logic                      in_valid,
    output logic                      in_ready,
    input  sc3_pkg::pix_t             pixel_in,

    // result channel
    output logic                      out_valid,
    input  logic                      out_ready,
    output sc3_pkg::pix_t             pixel_out,
    output logic                      row_end,
    output logic                      frame_end
);
    import sc3_pkg::*;

    // column counter indexes the line buffers; width/height compares need one more bit
    localparam int CW = $clog2(MAX_LINE);
    localparam int WW = $clog2(MAX_LINE + 1);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int HW = $clog2(MAX_ROWS + 1);

    // configuration registers
    logic [1:0]          kernel_select_reg;
    pix_t                center_boost_reg;
    logic [WIDTH_W-1:0]  image_width_reg;
    logic [HEIGHT_W-1:0] image_height_reg;

    // raster position of the next beat
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    logic [WW-1:0] width_use, width_m1;
    logic [HW-1:0] height_use, height_m1;
    logic          line_last, frame_last;
    sc3_tag_t      in_tag;

    // stage 1: pixel waiting for its line-buffer reads
    logic          s1_valid_reg;
    pix_t          s1_pix_reg;
    sc3_tag_t      s1_tag_reg;
    logic [CW-1:0] s1_col_reg;

    // output register
    logic out_valid_reg;
    pix_t pixel_out_reg;
    logic row_end_reg;
    logic frame_end_reg;

    logic in_accept;
    logic s1_advance;
    pix_t up_rd, mid_rd;
    pix_t conv_result;
    sc3_filt_cfg_t filt_cfg;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_select_reg <= KERN_CROSS_LAP;
            center_boost_reg  <= '0;
            image_width_reg   <= WIDTH_W'(1024);
            image_height_reg  <= HEIGHT_W'(1024);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_KERNEL_SELECT: kernel_select_reg <= cfg_data[1:0];
                REG_CENTER_BOOST:  center_boost_reg  <= cfg_data[PIX_W-1:0];
                REG_IMAGE_WIDTH:   image_width_reg   <= cfg_data[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data[HEIGHT_W-1:0];
                default:           ;
            endcase
        end
    end

    assign filt_cfg.kernel_select = kernel_select_reg;
    assign filt_cfg.center_boost  = center_boost_reg;

    // saturate frame dimensions
    always_comb
    begin
        if (32'(image_width_reg) < 32'(MIN_DIM))
        begin
            width_use = WW'(MIN_DIM);
        end
        else if (32'(image_width_reg) > 32'(MAX_LINE))
        begin
            width_use = WW'(MAX_LINE);
        end
        else
        begin
            width_use = WW'(image_width_reg);
        end

        if (32'(image_height_reg) < 32'(MIN_DIM))
        begin
            height_use = HW'(MIN_DIM);
        end
        else if (32'(image_height_reg) > 32'(MAX_ROWS))
        begin
            height_use = HW'(MAX_ROWS);
        end
        else
        begin
            height_use = HW'(image_height_reg);
        end
    end

    assign width_m1  = width_use - WW'(1);
    assign height_m1 = height_use - HW'(1);

    // ---------------- handshake ----------------
    // stage 1 moves on whenever the output register is free or being drained
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_accept  = in_valid && in_ready;

    // ---------------- raster counters ----------------
    assign line_last  = WW'(col_reg) >= width_m1;
    assign frame_last = line_last && (HW'(row_reg) >= height_m1);

    assign in_tag.produce   = (WW'(col_reg) >= WW'(2)) && (HW'(row_reg) >= HW'(2));
    assign in_tag.row_end   = line_last;
    assign in_tag.frame_end = frame_last;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (line_last)
        begin
            col_next = '0;
            row_next = frame_last ? '0 : RW'(row_reg + 1'b1);
        end
        else
        begin
            col_next = CW'(col_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- line buffers ----------------
    // middle line: written with the new pixel at accept, old word read out
    sc3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_LINE)
    ) u_line_mid (
        .clk   (clk),
        .we    (in_accept),
        .waddr (col_reg),
        .wdata (pixel_in),
        .re    (in_accept),
        .raddr (col_reg),
        .rdata (mid_rd)
    );

    // upper line: takes the old middle word once it has been read, when stage 1 advances
    sc3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_LINE)
    ) u_line_up (
        .clk   (clk),
        .we    (s1_advance),
        .waddr (s1_col_reg),
        .wdata (mid_rd),
        .re    (in_accept),
        .raddr (col_reg),
        .rdata (up_rd)
    );

    // ---------------- stage 1 ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_pix_reg <= pixel_in;
            s1_tag_reg <= in_tag;
            s1_col_reg <= col_reg;
        end
    end

    // ---------------- window and kernel ----------------
    sc3_conv_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (s1_advance),
        .up_pix   (up_rd),
        .mid_pix  (mid_rd),
        .new_pix  (s1_pix_reg),
        .filt_cfg (filt_cfg),
        .result   (conv_result)
    );

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance && s1_tag_reg.produce)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_tag_reg.produce)
        begin
            pixel_out_reg <= conv_result;
            row_end_reg   <= s1_tag_reg.row_end;
            frame_end_reg <= s1_tag_reg.frame_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_out_reg;
    assign row_end   = row_end_reg;
    assign frame_end = frame_end_reg;

endmodule
